@@ hdl/pps_pkg.sv @@
// Shared constants, request and status codes, and control structs of the joint smoother.
package pps_pkg;

	localparam int REQ_W      = 3;
	localparam int JIDX_W     = 3;
	localparam int VAL_W      = 24;
	localparam int POSE_W     = 7;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_W     = 16;
	localparam int DBAND_W    = 12;
	localparam int DWELL_W    = 16;
	localparam int JCNT_W     = 4;
	localparam int JSEL_W     = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DBAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_JCNT  = 2'd3;

	localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd9830;
	localparam logic [DBAND_W-1:0] DBAND_RST = 12'd4;
	localparam logic [DWELL_W-1:0] DWELL_RST = 16'd60;
	localparam logic [JCNT_W-1:0]  JCNT_RST  = 4'd4;

	localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SAVE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;
	localparam logic [REQ_W-1:0] REQ_START = 3'd5;
	localparam logic [REQ_W-1:0] REQ_STOP  = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] ST_REFUSED = 2'd3;

	typedef struct packed {
		logic              idle;
		logic              issue;
		logic              play;
		logic              ld_rd;
		logic              save_wr;
		logic              exec;
		logic              emit;
		logic              last;
		logic [JSEL_W-1:0] jsel;
	} pps_cmd_t;

	typedef struct packed {
		logic              in_valid;
		logic [REQ_W-1:0]  req;
		logic              save_ok;
		logic              ld_go;
		logic              pipe_busy;
		logic              out_free;
		logic [JSEL_W-1:0] jc;
	} pps_sts_t;

endpackage

@@ hdl/pps_req_if.sv @@
// Request channel: valid/ready handshake with the request payload.
interface pps_req_if;
	import pps_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic [JIDX_W-1:0]        joint_index;
	logic signed [VAL_W-1:0]  target_value;

	modport source (output valid, output req_type, output joint_index, output target_value,
		input ready);
	modport sink (input valid, input req_type, input joint_index, input target_value,
		output ready);
endinterface

@@ hdl/pps_res_if.sv @@
// Result channel: valid/ready handshake with the per-joint result payload.
interface pps_res_if;
	import pps_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [JIDX_W-1:0]        joint_number;
	logic signed [VAL_W-1:0]  joint_pos;
	logic                     any_moving;
	logic [POSE_W-1:0]        playing_pose;
	logic [POSE_W-1:0]        stored_poses;
	logic [STAT_W-1:0]        status;
	logic                     last;

	modport source (output valid, output joint_number, output joint_pos, output any_moving,
		output playing_pose, output stored_poses, output status, output last, input ready);
	modport sink (input valid, input joint_number, input joint_pos, input any_moving,
		input playing_pose, input stored_poses, input status, input last, output ready);
endinterface

@@ hdl/pps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/pps_ctrl.sv @@
// Controller state machine: sequences joint walk, playback step, pose load, save and results.
module pps_ctrl #(
	parameter int MAX_JOINTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pps_pkg::pps_sts_t  sts,
	output pps_pkg::pps_cmd_t  cmd
);
	import pps_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_UPD   = 4'd2;
	localparam logic [3:0] S_DRAIN = 4'd3;
	localparam logic [3:0] S_PLAY  = 4'd4;
	localparam logic [3:0] S_LOAD  = 4'd5;
	localparam logic [3:0] S_SAVE  = 4'd6;
	localparam logic [3:0] S_EXEC  = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	localparam logic [JSEL_W-1:0] J_ONE  = JSEL_W'(1);
	localparam logic [JSEL_W-1:0] J_LAST = JSEL_W'(MAX_JOINTS - 1);

	logic [3:0]        state_q, state_d;
	logic [JSEL_W-1:0] j_q, j_d;
	logic              jc_end;

	assign jc_end = (j_q == sts.jc - J_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.jsel = j_q;
		state_d  = state_q;
		j_d      = j_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				j_d      = '0;
				if (sts.in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				priority if (sts.req == REQ_TICK) begin
					state_d = S_UPD;
				end else if (sts.req == REQ_SAVE && sts.save_ok) begin
					state_d = S_SAVE;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_UPD: begin
				cmd.issue = 1'b1;
				if (jc_end) begin
					state_d = S_DRAIN;
				end else begin
					j_d = j_q + J_ONE;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_PLAY;
				end
			end
			S_PLAY: begin
				cmd.play = 1'b1;
				j_d      = '0;
				state_d  = sts.ld_go ? S_LOAD : S_EMIT;
			end
			S_LOAD: begin
				cmd.ld_rd = 1'b1;
				if (jc_end) begin
					j_d     = '0;
					state_d = S_EMIT;
				end else begin
					j_d = j_q + J_ONE;
				end
			end
			S_SAVE: begin
				cmd.save_wr = 1'b1;
				if (j_q == J_LAST) begin
					j_d     = '0;
					state_d = S_EXEC;
				end else begin
					j_d = j_q + J_ONE;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				j_d      = '0;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				cmd.last = (sts.req != REQ_TICK) || jc_end;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (cmd.last) begin
						state_d = S_IDLE;
					end else begin
						j_d = j_q + J_ONE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

@@ hdl/pps_dpath.sv @@
// Datapath: joint state, smoothing pipeline, pose store, playback counters and result register.
module pps_dpath #(
	parameter int MAX_JOINTS = 8,
	parameter int MAX_POSES  = 64,
	parameter int POS_WIDTH  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data,
	pps_req_if.sink                        req,
	pps_res_if.source                      res,
	input  pps_pkg::pps_cmd_t              cmd,
	output pps_pkg::pps_sts_t              sts
);
	import pps_pkg::*;

	localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int CW    = $clog2(MAX_POSES + 1);
	localparam int DEPTH = MAX_POSES * MAX_JOINTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = POS_WIDTH;
	localparam int PRODW = PW + GAIN_W;
	localparam logic signed [32:0] P_MAX = (33'sd1 <<< (PW - 1)) - 33'sd1;
	localparam logic signed [32:0] P_MIN = -(33'sd1 <<< (PW - 1));
	localparam logic [PRODW:0]    RND_HALF = (PRODW + 1)'(1) << (GAIN_W - 1);
	localparam logic [CW-1:0]     POSES_MAX = CW'(MAX_POSES);
	localparam logic [CW-1:0]     CW_ONE = CW'(1);
	localparam logic [AW-1:0]     AW_JOINTS = AW'(MAX_JOINTS);
	localparam logic [JSEL_W-1:0] JS_MAX = JSEL_W'(MAX_JOINTS);

	// configuration
	logic [GAIN_W-1:0]  gain_q;
	logic [DBAND_W-1:0] dband_q;
	logic [DWELL_W-1:0] dwell_q;
	logic [JCNT_W-1:0]  jcnt_q;

	// request held for the whole operation
	logic [REQ_W-1:0]    req_q;
	logic [JIDX_W-1:0]   idx_q;
	logic signed [PW-1:0] val_q;
	logic [STAT_W-1:0]   status_q;
	logic                moving_q;

	// joint and playback state
	logic signed [PW-1:0] pos_q [MAX_JOINTS];
	logic signed [PW-1:0] tgt_q [MAX_JOINTS];
	logic [CW-1:0]        total_q;
	logic [CW-1:0]        now_q;
	logic [DWELL_W-1:0]   tick_q;
	logic                 playing_q;

	// smoothing pipeline
	logic                 vld_s1, vld_s2;
	logic [JW-1:0]        j_s1, j_s2;
	logic                 neg_s1, neg_s2;
	logic                 move_s1, move_s2;
	logic [PW-1:0]        mag_s1;
	logic [PRODW-1:0]     prod_s2;
	logic signed [PW-1:0] pos_s1, pos_s2;

	logic          ld_v_q;
	logic [JW-1:0] ld_j_q;

	// result register
	logic                    out_valid_q;
	logic [JIDX_W-1:0]       onum_q;
	logic signed [VAL_W-1:0] opos_q;
	logic                    omov_q;
	logic [POSE_W-1:0]       opose_q;
	logic [POSE_W-1:0]       ostore_q;
	logic [STAT_W-1:0]       ostat_q;
	logic                    olast_q;

	// combinational
	logic                 accept;
	logic [JSEL_W-1:0]    jc_w;
	logic [JSEL_W-1:0]    rep_w;
	logic [JW-1:0]        jsel_w;
	logic [JW-1:0]        pos_ra;
	logic signed [PW-1:0] pos_rd;
	logic signed [PW-1:0] tgt_rd;
	logic [PW:0]          diff_w;
	logic [PW-1:0]        mag_w;
	logic signed [32:0]   vx_w;
	logic signed [PW-1:0] val_sat;
	logic [PRODW:0]       sum_w;
	logic [PW-1:0]        step_w;
	logic [PW:0]          upd_w;
	logic [DWELL_W:0]     cnt1_w;
	logic [DWELL_W-1:0]   dwell_eff;
	logic                 wrap_w;
	logic                 ld_go_w;
	logic                 set_ok;
	logic [CW-1:0]        pose_sel;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [AW-1:0]        ram_raddr;
	logic [PW-1:0]        ram_wdata;
	logic [PW-1:0]        ram_rdata;

	assign accept    = req.valid && cmd.idle;
	assign req.ready = cmd.idle;
	assign jsel_w    = cmd.jsel[JW-1:0];

	always_comb begin
		priority if (jcnt_q == '0) begin
			jc_w = JSEL_W'(1);
		end else if (JSEL_W'(jcnt_q) > JS_MAX) begin
			jc_w = JS_MAX;
		end else begin
			jc_w = JSEL_W'(jcnt_q);
		end
	end

	// report joint: set target folds its index into the joint range, others report joint zero
	always_comb begin
		rep_w = (req_q == REQ_SET) ? JSEL_W'(idx_q) : '0;
		for (int k = 0; k < 8; k++) begin
			if (rep_w >= JS_MAX) begin
				rep_w = rep_w - JS_MAX;
			end
		end
	end

	assign pos_ra = (cmd.save_wr || req_q == REQ_TICK) ? jsel_w : rep_w[JW-1:0];
	assign pos_rd = pos_q[pos_ra];
	assign tgt_rd = tgt_q[jsel_w];

	assign diff_w = {tgt_rd[PW-1], tgt_rd} - {pos_rd[PW-1], pos_rd};
	assign mag_w  = diff_w[PW] ? PW'(-diff_w) : PW'(diff_w);

	assign vx_w = 33'(req.target_value);
	always_comb begin
		priority if (vx_w > P_MAX) begin
			val_sat = PW'(P_MAX);
		end else if (vx_w < P_MIN) begin
			val_sat = PW'(P_MIN);
		end else begin
			val_sat = PW'(vx_w);
		end
	end

	assign sum_w  = {1'b0, prod_s2} + RND_HALF;
	assign step_w = PW'(sum_w >> GAIN_W);
	assign upd_w  = {pos_s2[PW-1], pos_s2} + (neg_s2 ? -{1'b0, step_w} : {1'b0, step_w});

	assign dwell_eff = (dwell_q == '0) ? DWELL_W'(1) : dwell_q;
	assign cnt1_w    = {1'b0, tick_q} + (DWELL_W + 1)'(1);
	assign wrap_w    = cnt1_w >= {1'b0, dwell_eff};
	assign ld_go_w   = playing_q && wrap_w && (total_q != '0);
	assign set_ok    = JSEL_W'(idx_q) < jc_w;

	assign pose_sel  = now_q - CW_ONE;
	assign ram_we    = cmd.save_wr;
	assign ram_waddr = AW'(total_q) * AW_JOINTS + AW'(cmd.jsel);
	assign ram_raddr = AW'(pose_sel) * AW_JOINTS + AW'(cmd.jsel);
	assign ram_wdata = pos_rd;

	pps_ram #(
		.WIDTH (PW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			dband_q <= DBAND_RST;
			dwell_q <= DWELL_RST;
			jcnt_q  <= JCNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_DBAND: dband_q <= cfg_data[DBAND_W-1:0];
				CFG_DWELL: dwell_q <= cfg_data[DWELL_W-1:0];
				CFG_JCNT:  jcnt_q  <= cfg_data[JCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.req_type;
			idx_q <= req.joint_index;
			val_q <= val_sat;
		end
	end

	// smoothing pipeline: read and compare, multiply, round and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		j_s1    <= jsel_w;
		neg_s1  <= diff_w[PW];
		mag_s1  <= mag_w;
		move_s1 <= mag_w > PW'(dband_q);
		pos_s1  <= pos_rd;
		j_s2    <= j_s1;
		neg_s2  <= neg_s1;
		move_s2 <= move_s1;
		pos_s2  <= pos_s1;
		prod_s2 <= PRODW'(mag_s1) * PRODW'(gain_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_JOINTS; k++) begin
				pos_q[k] <= '0;
			end
		end else if (vld_s2 && move_s2) begin
			pos_q[j_s2] <= upd_w[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_q <= 1'b0;
			ld_j_q <= '0;
		end else begin
			ld_v_q <= cmd.ld_rd;
			ld_j_q <= jsel_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_JOINTS; k++) begin
				tgt_q[k] <= '0;
			end
		end else if (ld_v_q) begin
			tgt_q[ld_j_q] <= ram_rdata;
		end else if (cmd.exec && req_q == REQ_SET && set_ok) begin
			tgt_q[JW'(idx_q)] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			now_q     <= '0;
			tick_q    <= '0;
			playing_q <= 1'b0;
			status_q  <= ST_OK;
			moving_q  <= 1'b0;
		end else begin
			if (accept) begin
				status_q <= ST_OK;
				moving_q <= 1'b0;
			end
			if (vld_s2 && move_s2) begin
				moving_q <= 1'b1;
			end
			if (cmd.play && playing_q) begin
				tick_q <= wrap_w ? '0 : cnt1_w[DWELL_W-1:0];
				if (ld_go_w) begin
					now_q <= (now_q >= total_q) ? CW_ONE : now_q + CW_ONE;
				end
			end
			if (cmd.exec) begin
				unique case (req_q)
					REQ_SAVE: begin
						priority if (playing_q) begin
							status_q <= ST_REFUSED;
						end else if (total_q >= POSES_MAX) begin
							status_q <= ST_FULL;
						end else begin
							total_q <= total_q + CW_ONE;
						end
					end
					REQ_DEL: begin
						priority if (playing_q) begin
							status_q <= ST_REFUSED;
						end else if (total_q == '0) begin
							status_q <= ST_EMPTY;
						end else begin
							total_q <= total_q - CW_ONE;
						end
					end
					REQ_CLEAR: begin
						total_q   <= '0;
						now_q     <= '0;
						tick_q    <= '0;
						playing_q <= 1'b0;
					end
					REQ_START: begin
						playing_q <= 1'b1;
						if (total_q == '0) begin
							status_q <= ST_EMPTY;
						end
					end
					REQ_STOP: begin
						playing_q <= 1'b0;
						now_q     <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			onum_q   <= (req_q == REQ_TICK) ? JIDX_W'(cmd.jsel) : JIDX_W'(rep_w);
			opos_q   <= VAL_W'(pos_rd);
			omov_q   <= moving_q;
			opose_q  <= POSE_W'(now_q);
			ostore_q <= POSE_W'(total_q);
			ostat_q  <= status_q;
			olast_q  <= cmd.last;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.joint_number = onum_q;
	assign res.joint_pos    = opos_q;
	assign res.any_moving   = omov_q;
	assign res.playing_pose = opose_q;
	assign res.stored_poses = ostore_q;
	assign res.status       = ostat_q;
	assign res.last         = olast_q;

	assign sts.in_valid  = req.valid;
	assign sts.req       = req_q;
	assign sts.save_ok   = !playing_q && (total_q < POSES_MAX);
	assign sts.ld_go     = ld_go_w;
	assign sts.pipe_busy = vld_s1 || vld_s2;
	assign sts.out_free  = !out_valid_q || res.ready;
	assign sts.jc        = jc_w;

	a_total_max: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= POSES_MAX)
		else $error("pose count beyond store size");

	a_now_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		now_q <= total_q)
		else $error("playback pose beyond stored poses");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || res.ready))
		else $error("result overwritten before taken");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1))
		else $error("writeback without multiply stage");

	a_load_pose: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_rd |-> (now_q != '0))
		else $error("pose load with no pose selected");
endmodule

@@ hdl/pose_playback_joint_smoother_top.sv @@
// Top level of the pose playback joint smoother: controller plus datapath.
//
// Requests enter on req (valid/ready), results leave on res (valid/ready);
// a request is taken when valid and ready are both high. The user must write
// the configuration registers (gain, deadband, dwell, joint count) through
// cfg_we/cfg_idx/cfg_data only while no request is in flight; not enforced.
// A tick walks the N joints in use through one shared multiplier pipeline,
// one joint per cycle, then steps playback and, on a dwell wrap with poses
// stored, reads N target entries from the pose store one per cycle. It then
// returns N results, one per cycle while res is taken, last on the final one.
// A new request is taken only once the previous one has issued its last
// result. Save pose, unless playing or the store is full, writes all joints
// into the store, one per cycle. Other requests give one result.
// A finished result waits in the output register; the next request is taken
// while it waits, and a stalled receiver holds further results in place.
// Reset zeroes positions, targets, pose count and playback state and loads
// the default configuration; the pose store contents are left as they are.
module pose_playback_joint_smoother_top #(
	parameter int MAX_JOINTS = 8,
	parameter int MAX_POSES  = 64,
	parameter int POS_WIDTH  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data,
	pps_req_if.sink                        req,
	pps_res_if.source                      res
);
	import pps_pkg::*;

	pps_cmd_t cmd;
	pps_sts_t sts;

	pps_ctrl #(
		.MAX_JOINTS (MAX_JOINTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pps_dpath #(
		.MAX_JOINTS (MAX_JOINTS),
		.MAX_POSES  (MAX_POSES),
		.POS_WIDTH  (POS_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req),
		.res      (res),
		.cmd      (cmd),
		.sts      (sts)
	);
endmodule
